// ===== hdl/ipdf_pkg.sv =====
package ipdf_pkg;

  localparam int unsigned WindowBytes  = 8;
  localparam int unsigned LengthDigits = 3;

  localparam int unsigned WindowW = 8 * WindowBytes;
  localparam int unsigned KwLenW  = 4;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned LenW    = 10;
  localparam int unsigned DigitsW = $clog2(LengthDigits + 1);
  localparam int unsigned StatusW = 3;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 64;

  localparam logic [LenW-1:0] LenMax = LenW'(1023);

  localparam logic [7:0] CharComma = 8'h2c;
  localparam logic [7:0] CharColon = 8'h3a;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [WindowW-1:0] KeywordReset   = WindowW'(64'd185913590828);
  localparam logic [KwLenW-1:0]  KwLenReset     = KwLenW'(5);
  localparam logic [TimeW-1:0]   SearchToReset  = TimeW'(1600);
  localparam logic [TimeW-1:0]   PacketToReset  = TimeW'(1000);

  typedef enum logic [1:0] {
    RegKeywordChars  = 2'd0,
    RegKeywordLength = 2'd1,
    RegSearchTimeout = 2'd2,
    RegPacketTimeout = 2'd3
  } reg_idx_e;

  typedef enum logic [StatusW-1:0] {
    StPayload   = 3'd0,
    StSearchTo  = 3'd1,
    StHeaderTo  = 3'd2,
    StPayloadTo = 3'd3,
    StEmpty     = 3'd4
  } status_e;

  typedef enum logic {
    OpByte = 1'b0,
    OpTick = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [WindowW-1:0] keyword_chars;
    logic [KwLenW-1:0]  keyword_length;
    logic [TimeW-1:0]   search_timeout;
    logic [TimeW-1:0]   packet_timeout;
  } cfg_t;

  function automatic logic [TimeW-1:0] load_time(input logic [TimeW-1:0] t);
    return (t == '0) ? TimeW'(1) : t;
  endfunction

endpackage

// ===== hdl/ipdf_cfg_regs.sv =====
module ipdf_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ipdf_pkg::AddrW-1:0]  paddr,
  input  logic [ipdf_pkg::DataW-1:0]  pwdata,
  output logic [ipdf_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output ipdf_pkg::cfg_t              cfg_o
);
  import ipdf_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[AddrW-1:AddrW-2]);
  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegKeywordChars:  cfg_d.keyword_chars  = pwdata[WindowW-1:0];
        RegKeywordLength: cfg_d.keyword_length = pwdata[KwLenW-1:0];
        RegSearchTimeout: cfg_d.search_timeout = pwdata[TimeW-1:0];
        RegPacketTimeout: cfg_d.packet_timeout = pwdata[TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegKeywordChars:  prdata = DataW'(cfg_q.keyword_chars);
      RegKeywordLength: prdata = DataW'(cfg_q.keyword_length);
      RegSearchTimeout: prdata = DataW'(cfg_q.search_timeout);
      RegPacketTimeout: prdata = DataW'(cfg_q.packet_timeout);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.keyword_chars  <= KeywordReset;
      cfg_q.keyword_length <= KwLenReset;
      cfg_q.search_timeout <= SearchToReset;
      cfg_q.packet_timeout <= PacketToReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/at_ipd_packet_deframer_unit.sv =====
// Deframer for "+IPD,<id>,<len>:<payload>" packets arriving as UART bytes mixed with
// millisecond ticks. It takes one beat per cycle unless stalled and gives at most one
// result beat from an output register in the cycle after the input beat; the input stays
// ready while that register is empty or being emptied, so it sustains one item per cycle.
// Payload beats carry the announced length and mark the final byte with last; a search,
// header or payload timeout and an empty packet each give one status beat with last set.
module at_ipd_packet_deframer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ipdf_pkg::StatusW-1:0]  status_o,
  output logic [7:0]                    data_byte_o,
  output logic                          last_o,
  output logic [ipdf_pkg::LenW-1:0]     packet_length_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ipdf_pkg::AddrW-1:0]    paddr,
  input  logic [ipdf_pkg::DataW-1:0]    pwdata,
  output logic [ipdf_pkg::DataW-1:0]    prdata,
  output logic                          pready
);
  import ipdf_pkg::*;

  localparam logic [1:0] PhSearch  = 2'd0;
  localparam logic [1:0] PhComma   = 2'd1;
  localparam logic [1:0] PhDigits  = 2'd2;
  localparam logic [1:0] PhPayload = 2'd3;

  cfg_t cfg;

  ipdf_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic [1:0]         phase_q, phase_d;
  logic [WindowW-1:0] window_q, window_d;
  logic [TimeW-1:0]   deadline_q, deadline_d;
  logic [LenW-1:0]    acc_q, acc_d;
  logic [DigitsW-1:0] digits_q, digits_d;
  logic [LenW-1:0]    remain_q, remain_d;
  logic               closed_q, closed_d;

  logic               out_valid_q, out_valid_d;
  status_e            status_q, status_d;
  logic [7:0]         data_q, data_d;
  logic               last_q, last_d;
  logic [LenW-1:0]    len_q, len_d;

  logic               accept;
  logic               emit;
  logic [KwLenW-1:0]  k_eff;
  logic [WindowW-1:0] shifted;
  logic               match;
  logic [TimeW-1:0]   dl_dec;
  logic               is_digit;
  logic [LenW+3:0]    acc_mul;
  logic [LenW-1:0]    remain_dec;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (cfg.keyword_length == '0) begin
      k_eff = KwLenW'(1);
    end else if (cfg.keyword_length > KwLenW'(WindowBytes)) begin
      k_eff = KwLenW'(WindowBytes);
    end else begin
      k_eff = cfg.keyword_length;
    end
  end

  assign shifted = {window_q[WindowW-9:0], rx_byte_i};

  always_comb begin
    match = 1'b1;
    for (int j = 0; j < WindowBytes; j++) begin
      if ((KwLenW'(j) < k_eff) && (shifted[8*j +: 8] != cfg.keyword_chars[8*j +: 8])) begin
        match = 1'b0;
      end
    end
  end

  assign dl_dec     = (deadline_q != '0) ? deadline_q - TimeW'(1) : '0;
  assign is_digit   = (rx_byte_i >= CharZero) && (rx_byte_i <= CharNine);
  assign acc_mul    = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                      + (LenW+4)'(rx_byte_i - CharZero);
  assign remain_dec = (remain_q != '0) ? remain_q - LenW'(1) : '0;

  always_comb begin
    phase_d    = phase_q;
    window_d   = window_q;
    deadline_d = deadline_q;
    acc_d      = acc_q;
    digits_d   = digits_q;
    remain_d   = remain_q;
    closed_d   = closed_q;
    emit       = 1'b0;
    status_d   = StPayload;
    data_d     = '0;
    last_d     = 1'b1;
    len_d      = '0;

    if (opcode_e'(opcode_i) == OpTick) begin
      deadline_d = dl_dec;
      if (dl_dec == '0) begin
        emit = 1'b1;
        unique case (phase_q)
          PhSearch:  status_d = StSearchTo;
          PhPayload: begin
            status_d = StPayloadTo;
            len_d    = acc_q;
          end
          default:   status_d = StHeaderTo;
        endcase
        phase_d    = PhSearch;
        deadline_d = load_time(cfg.search_timeout);
        acc_d      = '0;
        digits_d   = '0;
        remain_d   = '0;
        closed_d   = 1'b0;
      end
    end else begin
      unique case (phase_q)
        PhSearch: begin
          window_d = shifted;
          if (match) begin
            phase_d    = PhComma;
            deadline_d = load_time(cfg.packet_timeout);
          end
        end
        PhComma: begin
          if (rx_byte_i == CharComma) begin
            phase_d  = PhDigits;
            acc_d    = '0;
            digits_d = '0;
            closed_d = 1'b0;
          end
        end
        PhDigits: begin
          if ((rx_byte_i == CharColon) || (digits_q >= DigitsW'(LengthDigits))) begin
            if (acc_q == '0) begin
              emit       = 1'b1;
              status_d   = StEmpty;
              phase_d    = PhSearch;
              deadline_d = load_time(cfg.search_timeout);
              acc_d      = '0;
              digits_d   = '0;
              remain_d   = '0;
              closed_d   = 1'b0;
            end else begin
              phase_d    = PhPayload;
              remain_d   = acc_q;
              deadline_d = load_time(cfg.packet_timeout);
            end
          end else begin
            digits_d = digits_q + DigitsW'(1);
            if (!closed_q && is_digit) begin
              acc_d = (acc_mul > (LenW+4)'(LenMax)) ? LenMax : acc_mul[LenW-1:0];
            end else begin
              closed_d = 1'b1;
            end
          end
        end
        PhPayload: begin
          emit     = 1'b1;
          status_d = StPayload;
          data_d   = rx_byte_i;
          last_d   = (remain_q <= LenW'(1));
          len_d    = acc_q;
          remain_d = remain_dec;
          if (remain_dec == '0) begin
            phase_d    = PhSearch;
            deadline_d = load_time(cfg.search_timeout);
            acc_d      = '0;
            digits_d   = '0;
            closed_d   = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (accept && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhSearch;
      window_q    <= '0;
      deadline_q  <= load_time(SearchToReset);
      acc_q       <= '0;
      digits_q    <= '0;
      remain_q    <= '0;
      closed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q    <= phase_d;
        window_q   <= window_d;
        deadline_q <= deadline_d;
        acc_q      <= acc_d;
        digits_q   <= digits_d;
        remain_q   <= remain_d;
        closed_q   <= closed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      status_q <= status_d;
      data_q   <= data_d;
      last_q   <= last_d;
      len_q    <= len_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign data_byte_o     = data_q;
  assign last_o          = last_q;
  assign packet_length_o = len_q;

endmodule

// ===== hdl/ipdf_checker.sv =====
module ipdf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [ipdf_pkg::StatusW-1:0]  status_o,
  input logic [7:0]                    data_byte_o,
  input logic                          last_o,
  input logic [ipdf_pkg::LenW-1:0]     packet_length_o
);
  import ipdf_pkg::*;

  // A result beat held back by the sink keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(data_byte_o) && $stable(last_o) && $stable(packet_length_o))
    else $error("stalled result beat changed");

  // The input only stalls behind a full, stalled output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without back pressure");

  // Every status beat closes its packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != StPayload) |-> last_o && (data_byte_o == 8'h00))
    else $error("status beat without last or with data");

  // Search and header timeouts carry no length, an empty packet neither.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == StSearchTo) || (status_o == StHeaderTo)
      || (status_o == StEmpty)) |-> (packet_length_o == '0))
    else $error("length on a beat without a packet");

  // A payload beat belongs to a packet of nonzero length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StPayload) |-> (packet_length_o != '0))
    else $error("payload beat with zero length");

endmodule

bind at_ipd_packet_deframer_unit ipdf_checker u_ipdf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .data_byte_o     (data_byte_o),
  .last_o          (last_o),
  .packet_length_o (packet_length_o)
);
